// ----- design/ldre_pkg.sv -----
// package for the lan designated router election block
// types, constants and field widths shared by all design files; no dependencies
package ldre_pkg;

    localparam int unsigned MaxNeighbours = 32;

    localparam logic [1:0] OpRouterHello  = 2'd0;
    localparam logic [1:0] OpEndnodeHello = 2'd1;
    localparam logic [1:0] OpTimeout      = 2'd2;
    localparam logic [1:0] OpDelayExpired = 2'd3;

    localparam logic [1:0] TypeEnd = 2'd0;
    localparam logic [1:0] TypeL1  = 2'd1;
    localparam logic [1:0] TypeL2  = 2'd2;

    localparam logic [1:0] AdjNone = 2'd0;
    localparam logic [1:0] AdjUp   = 2'd1;
    localparam logic [1:0] AdjDown = 2'd2;

    localparam logic [1:0] CfgOwnNodeId   = 2'd0;
    localparam logic [1:0] CfgOwnPriority = 2'd1;
    localparam logic [1:0] CfgOwnAreaRtr  = 2'd2;

    localparam logic [15:0] OwnNodeIdReset   = 16'd1025;
    localparam logic [6:0]  OwnPriorityReset = 7'd64;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] node_id;
        logic [6:0]  priority_req;
        logic        is_level2;
        logic        self_listed;
    } t_in_item;

    typedef struct packed {
        logic        is_designated;
        logic [15:0] dr_node;
        logic        timer_start;
        logic        timer_stop;
        logic        hello_now;
        logic [1:0]  adj_event;
        logic [15:0] event_node;
        logic        table_full;
    } t_out_item;

    // one table entry: up, type, priority, id (valid kept in flip-flops)
    typedef struct packed {
        logic        up;
        logic [1:0]  ntype;
        logic [6:0]  prio;
        logic [15:0] id;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic scan_clear;  // start a table scan
        logic scan_step;   // examine one entry
        logic latch_in;    // capture input item
        logic do_write;    // apply hello or timeout to chosen entry
        logic elect_clear; // seed election with own values
        logic decide;      // evaluate result of the operation
        logic out_load;    // load output register
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
    } t_stat;

    function automatic logic [5:0] area_of(input logic [15:0] id);
        return id[15:10];
    endfunction

endpackage

// ----- design/ldre_if.sv -----
// valid/ready channel interfaces for items and configuration writes
// depends on ldre_pkg for payload types
interface ldre_in_if;
    logic                 valid;
    logic                 ready;
    ldre_pkg::t_in_item   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ldre_out_if;
    logic                 valid;
    logic                 ready;
    ldre_pkg::t_out_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ldre_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ----- design/lan_designated_router_election.sv -----
// A result is set by two serial passes over the neighbour table memory, one entry per cycle:
// a search pass, the table write, then an election pass and the decision.
// A new item is not accepted until the previous result has been taken; input stays
// blocked while a result waits.
// Reset (synchronous, active low): table empty via valid flip-flops, not designated,
// no delay running, dr_node 0; config registers return to their defaults.
module lan_designated_router_election #(
    parameter int unsigned MAX_NEIGHBOURS = ldre_pkg::MaxNeighbours
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ldre_in_if.sink    in_ch,
    ldre_out_if.source out_ch,
    ldre_cfg_if.sink   cfg_ch
);
    ldre_pkg::t_ctrl ctrl;
    ldre_pkg::t_stat stat;
    logic [15:0] r_own_id;
    logic [6:0]  r_own_prio;
    logic        r_own_area;

    // configuration registers
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id <= ldre_pkg::OwnNodeIdReset;
            r_own_prio <= ldre_pkg::OwnPriorityReset;
            r_own_area <= 1'b0;
        end else if (cfg_ch.valid) begin
            unique case (cfg_ch.index)
                ldre_pkg::CfgOwnNodeId:   r_own_id <= cfg_ch.wdata;
                ldre_pkg::CfgOwnPriority: r_own_prio <= cfg_ch.wdata[6:0];
                ldre_pkg::CfgOwnAreaRtr:  r_own_area <= cfg_ch.wdata[0];
                default: ;
            endcase
        end
    end

    ldre_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_stat(stat), .o_ctrl(ctrl)
    );

    ldre_datapath #(.MAX_NEIGHBOURS(MAX_NEIGHBOURS)) u_dp (
        .i_clk, .i_rst_n,
        .i_ctrl(ctrl), .o_stat(stat), .i_item(in_ch.data),
        .i_own_id(r_own_id), .i_own_prio(r_own_prio), .i_own_area(r_own_area),
        .o_result(out_ch.data)
    );
endmodule

// ----- design/ldre_datapath.sv -----
// datapath: neighbour table memory, search/election scan and result register
// depends on ldre_pkg
module ldre_datapath #(
    parameter int unsigned MAX_NEIGHBOURS = ldre_pkg::MaxNeighbours
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ldre_pkg::t_ctrl     i_ctrl,
    output ldre_pkg::t_stat     o_stat,
    input  ldre_pkg::t_in_item  i_item,
    input  logic [15:0]         i_own_id,
    input  logic [6:0]          i_own_prio,
    input  logic                i_own_area,
    output ldre_pkg::t_out_item o_result
);
    localparam int unsigned Aw = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
    localparam logic [Aw-1:0] LastIdx = Aw'(MAX_NEIGHBOURS - 1);

    ldre_pkg::t_entry r_mem [MAX_NEIGHBOURS];
    logic [MAX_NEIGHBOURS-1:0] r_valid;
    ldre_pkg::t_in_item r_item;
    logic [Aw-1:0] r_idx;
    ldre_pkg::t_entry r_rd;
    logic          r_rd_ok;
    logic [Aw-1:0] r_rd_idx;
    // search results
    logic          r_found, r_free_ok;
    logic [Aw-1:0] r_found_idx, r_free_idx;
    ldre_pkg::t_entry r_found_e;
    // election running best
    logic [6:0]    r_bp;
    logic [15:0]   r_bid;
    logic          r_self;
    // operation effects recorded at write time
    logic          r_run_elect, r_full, r_hello, r_elect_pending;
    logic [1:0]    r_ev;
    logic [15:0]   r_evnode;
    // persistent state
    logic          r_acting, r_delay;
    logic [15:0]   r_elected;
    ldre_pkg::t_out_item r_out;

    logic in_area, accept_hello;
    ldre_pkg::t_entry rd_view, n_entry;
    logic n_valid_bit;

    assign o_stat.scan_last = (r_idx == LastIdx);
    assign o_result = r_out;

    // entry being examined this scan cycle, registered read
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_idx];
        r_rd_idx <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ok <= 1'b0;
        end else begin
            r_rd_ok <= i_ctrl.scan_step;
        end
    end

    assign rd_view = r_rd;
    assign in_area = ldre_pkg::area_of(r_item.node_id) == ldre_pkg::area_of(i_own_id);

    always_comb begin
        accept_hello = 1'b0;
        case (r_item.op)
            ldre_pkg::OpRouterHello:  accept_hello = in_area || (r_item.is_level2 && i_own_area);
            ldre_pkg::OpEndnodeHello: accept_hello = in_area;
            default:                  accept_hello = 1'b0;
        endcase
    end

    // new entry contents for the chosen slot
    always_comb begin
        n_entry = r_found ? r_found_e : '0;
        n_entry.id = r_item.node_id;
        n_valid_bit = 1'b1;
        if (r_item.op == ldre_pkg::OpRouterHello) begin
            n_entry.prio = r_item.priority_req;
            n_entry.ntype = r_item.is_level2 ? ldre_pkg::TypeL2 : ldre_pkg::TypeL1;
            if (r_item.self_listed) n_entry.up = 1'b1;
        end else if (r_item.op == ldre_pkg::OpEndnodeHello) begin
            if (!n_entry.up) begin
                n_entry.ntype = ldre_pkg::TypeEnd;
                n_entry.prio = '0;
                n_entry.up = 1'b1;
            end
        end else begin
            n_entry = '0;
            n_valid_bit = 1'b0;
        end
    end

    // table memory and valid bits
    always_ff @(posedge i_clk) begin
        if (i_ctrl.do_write && (r_found || (accept_hello && r_free_ok))
            && r_item.op != ldre_pkg::OpTimeout && accept_hello) begin
            r_mem[r_found ? r_found_idx : r_free_idx] <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctrl.do_write) begin
            if (r_item.op == ldre_pkg::OpTimeout) begin
                if (r_found) r_valid[r_found_idx] <= 1'b0;
            end else if (accept_hello && (r_found || r_free_ok)) begin
                r_valid[r_found ? r_found_idx : r_free_idx] <= n_valid_bit;
            end
        end
    end

    // scan index, search and election
    always_ff @(posedge i_clk) begin
        if (i_ctrl.latch_in) r_item <= i_item;
        if (i_ctrl.scan_clear) begin
            r_idx <= '0;
        end else if (i_ctrl.scan_step && r_idx != LastIdx) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_ctrl.latch_in) begin
            r_found <= 1'b0;
            r_free_ok <= 1'b0;
        end else if (r_rd_ok) begin
            if (r_valid[r_rd_idx] && r_rd.id == r_item.node_id && !r_found) begin
                r_found <= 1'b1;
                r_found_idx <= r_rd_idx;
                r_found_e <= rd_view;
            end
            if (!r_valid[r_rd_idx] && !r_free_ok) begin
                r_free_ok <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
        end
        if (i_ctrl.elect_clear) begin
            r_bp <= i_own_prio;
            r_bid <= i_own_id;
            r_self <= 1'b1;
        end else if (r_rd_ok && !i_ctrl.latch_in && r_valid[r_rd_idx]
                     && rd_view.ntype != ldre_pkg::TypeEnd
                     && ldre_pkg::area_of(rd_view.id) == ldre_pkg::area_of(i_own_id)
                     && (rd_view.prio > r_bp || (rd_view.prio == r_bp && rd_view.id > r_bid)))
        begin
            r_bp <= rd_view.prio;
            r_bid <= rd_view.id;
            r_self <= 1'b0;
        end
    end

    // operation effects; elected state; output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acting <= 1'b0;
            r_delay <= 1'b0;
            r_elected <= '0;
            r_out <= '0;
            r_run_elect <= 1'b0;
            r_full <= 1'b0;
            r_hello <= 1'b0;
            r_ev <= ldre_pkg::AdjNone;
            r_evnode <= '0;
            r_elect_pending <= 1'b0;
        end else begin
            if (i_ctrl.do_write) begin
                r_run_elect <= 1'b0;
                r_full <= 1'b0;
                r_hello <= 1'b0;
                r_ev <= ldre_pkg::AdjNone;
                r_evnode <= '0;
                r_elect_pending <= 1'b0;
                case (r_item.op)
                    ldre_pkg::OpRouterHello: begin
                        if (accept_hello) begin
                            if (!r_found && !r_free_ok) begin
                                r_full <= 1'b1;
                            end else begin
                                r_run_elect <= 1'b1;
                                if (r_item.self_listed && !(r_found && r_found_e.up)) begin
                                    r_ev <= ldre_pkg::AdjUp;
                                    r_evnode <= r_item.node_id;
                                end
                            end
                        end
                    end
                    ldre_pkg::OpEndnodeHello: begin
                        if (accept_hello) begin
                            if (!r_found && !r_free_ok) begin
                                r_full <= 1'b1;
                            end else if (!(r_found && r_found_e.up)) begin
                                r_ev <= ldre_pkg::AdjUp;
                                r_evnode <= r_item.node_id;
                            end
                        end
                    end
                    ldre_pkg::OpTimeout: begin
                        if (r_found) begin
                            if (r_found_e.up) begin
                                r_ev <= ldre_pkg::AdjDown;
                                r_evnode <= r_item.node_id;
                            end
                            if (r_elected == r_item.node_id) r_elected <= '0;
                            if (r_found_e.ntype != ldre_pkg::TypeEnd) begin
                                r_run_elect <= 1'b1;
                                r_hello <= 1'b1;
                            end
                        end
                    end
                    default: begin
                        if (r_delay) begin
                            r_delay <= 1'b0;
                            r_elect_pending <= 1'b1;
                        end
                    end
                endcase
            end
            if (i_ctrl.decide) begin
                ldre_pkg::t_out_item o;
                o = '0;
                o.hello_now = r_hello;
                o.adj_event = r_ev;
                o.event_node = r_evnode;
                o.table_full = r_full;
                if (r_elect_pending && r_self) begin
                    r_acting <= 1'b1;
                    r_elected <= i_own_id;
                    o.hello_now = 1'b1;
                    o.is_designated = 1'b1;
                    o.dr_node = i_own_id;
                end else begin
                    o.is_designated = r_acting;
                    o.dr_node = r_elected;
                    if (r_run_elect || r_elect_pending) begin
                        if (r_self) begin
                            if (!r_acting && !r_delay) begin
                                r_delay <= 1'b1;
                                o.timer_start = 1'b1;
                            end
                        end else begin
                            if (r_acting) begin
                                r_acting <= 1'b0;
                                o.is_designated = 1'b0;
                                o.hello_now = 1'b1;
                            end
                            if (r_elected != r_bid) begin
                                r_delay <= 1'b0;
                                o.timer_stop = 1'b1;
                                r_elected <= r_bid;
                                o.dr_node = r_bid;
                            end
                        end
                    end
                end
                if (i_ctrl.out_load) r_out <= o;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.decide |=> (r_out.adj_event != ldre_pkg::AdjNone) == (r_out.event_node == r_item.node_id
        && r_out.adj_event != ldre_pkg::AdjNone) || r_out.adj_event == ldre_pkg::AdjNone)
        else $error("event node mismatch");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_acting && r_delay)) else $error("acting while delay runs");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.decide |=> !(r_out.timer_start && r_out.timer_stop))
        else $error("timer start and stop together");
endmodule

// ----- design/ldre_ctrl.sv -----
// controller: sequences search scan, table update, election scan, result
// depends on ldre_pkg
module ldre_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  ldre_pkg::t_stat i_stat,
    output ldre_pkg::t_ctrl o_ctrl
);
    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_DRAIN1, S_WRITE, S_ELECT, S_DRAIN2, S_DECIDE
    } t_state;

    t_state r_state, n_state;
    logic r_out_valid, n_out_valid;

    assign o_in_ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_ctrl = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_ctrl.latch_in = 1'b1;
                    o_ctrl.scan_clear = 1'b1;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_ctrl.scan_step = 1'b1;
                if (i_stat.scan_last) n_state = S_DRAIN1;
            end
            S_DRAIN1: n_state = S_WRITE;
            S_WRITE: begin
                o_ctrl.do_write = 1'b1;
                o_ctrl.scan_clear = 1'b1;
                o_ctrl.elect_clear = 1'b1;
                n_state = S_ELECT;
            end
            S_ELECT: begin
                o_ctrl.scan_step = 1'b1;
                if (i_stat.scan_last) n_state = S_DRAIN2;
            end
            S_DRAIN2: n_state = S_DECIDE;
            S_DECIDE: begin
                o_ctrl.decide = 1'b1;
                o_ctrl.out_load = 1'b1;
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |=> r_out_valid) else $error("result not presented");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid) else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_out_valid) else $error("accept while result pending");
endmodule
